// ===== src/iecfc_pkg.sv =====
// shared types and constants for the iec104 frame classifier
// no dependencies

`default_nettype none

package iecfc_pkg;

  // verdict codes
  typedef enum logic [2:0] {
    VD_OK          = 3'd0,
    VD_NOT_IPV4    = 3'd1,
    VD_NOT_TCP     = 3'd2,
    VD_FRAGMENTED  = 3'd3,
    VD_NOT_PROTO   = 3'd4,
    VD_MALFORMED   = 3'd5,
    VD_TRUNCATED   = 3'd6
  } verdict_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SERVICE_PORT = 1'b0,
    CFG_START_BYTE   = 1'b1
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] SERVICE_PORT_RESET = 16'd2404;
  localparam logic [7:0]  START_BYTE_RESET   = 8'h68;

  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  TCP_PROTOCOL_NUM = 8'd6;
  localparam logic [3:0]  MIN_HDR_WORDS    = 4'd5;
  localparam int unsigned MIN_PAYLOAD      = 6;
  // fragment field is flags/offset masked with 0x3fff: low six bits of the first byte
  localparam logic [7:0]  FRAG_HI_MASK     = 8'h3f;

endpackage : iecfc_pkg

`default_nettype wire

// ===== src/iecfc_ifs.sv =====
// valid/ready channel interfaces for the iec104 frame classifier
// depends on iecfc_pkg

`default_nettype none

interface iecfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface : iecfc_in_if

interface iecfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic        direction;
  logic [31:0] source_address;
  logic [31:0] destination_address;

  modport source (output valid, verdict, direction, source_address, destination_address,
                  input ready);
  modport sink   (input valid, verdict, direction, source_address, destination_address,
                  output ready);
endinterface : iecfc_out_if

interface iecfc_cfg_if
  import iecfc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [0:0]            index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : iecfc_cfg_if

`default_nettype wire

// ===== src/iec104_frame_classifier.sv =====
// top level of the iec104 frame classifier: ethernet/ipv4/tcp header checks per frame
// depends on iecfc_pkg and the channel interfaces in iecfc_ifs.sv

// usage
// - in_bus carries one frame byte per beat, starting at the destination mac;
//   last_byte marks the final byte of a frame
// - out_bus carries exactly one verdict beat per frame, with direction and the
//   ipv4 source/destination addresses (all zero unless the verdict is ok)
// - cfg_bus writes service_port (index 0) or start_byte (index 1); always ready,
//   write only while no frame is in flight
// - one byte per cycle sustained unless a final byte waits for the output register;
//   a byte is held in the input register, then the per-position header logic
//   updates frame state and, on the last byte, loads the verdict into the output
//   register, whose valid flag drives out_bus.valid
// - the only stall source is the output register: while it holds an untaken
//   verdict, non-final bytes still flow, and the next final byte waits in the
//   input register, which then drops in_bus.ready
// - synchronous active-low reset clears both registers' valid flags, the frame
//   state and restores the configuration defaults (port 2404, start byte 0x68)
// - frames longer than MAX_FRAME_BYTES are judged as if they had that length

`default_nettype none

module iec104_frame_classifier
  import iecfc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES  = 2048,
  parameter int unsigned ETH_HEADER_BYTES = 14
) (
  input  wire          clk,
  input  wire          rst_n,
  iecfc_in_if.sink     in_bus,
  iecfc_out_if.source  out_bus,
  iecfc_cfg_if.sink    cfg_bus
);

  // byte position counter and a one-bit-wider width for n = position + 1
  localparam int unsigned PW = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned NW = PW + 1;
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_BYTES - 1);
  localparam logic [NW-1:0] E_N     = NW'(ETH_HEADER_BYTES);

  // configuration registers
  logic [15:0] service_port_r;
  logic [7:0]  start_byte_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;

  // frame state
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    prev_r;
  logic [3:0]    ihw_r, ihw_nxt;
  logic [3:0]    thw_r, thw_nxt;
  logic [15:0]   sport_r, sport_nxt;
  logic [15:0]   dport_r, dport_nxt;
  logic [31:0]   saddr_r, saddr_nxt;
  logic [31:0]   daddr_r, daddr_nxt;
  logic          pay_ok_r, pay_ok_nxt;
  logic          eth_ok_r, eth_ok_nxt;
  logic          proto_ok_r, proto_ok_nxt;
  logic          frag_r, frag_nxt;

  // output register
  logic        out_valid_r;
  verdict_t    out_verdict_r;
  logic        out_dir_r;
  logic [31:0] out_saddr_r;
  logic [31:0] out_daddr_r;

  // handshake
  logic out_free;
  logic s1_fire;
  logic in_fire;

  // datapath
  logic [NW-1:0] pos_n, n, t_old, t_new, p_new;
  logic          hdr_ok;
  verdict_t      verdict_nxt;
  logic          dir_nxt;

  assign out_free = !out_valid_r || out_bus.ready;
  // only a final byte needs room in the output register
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_bus.ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_bus.valid && in_bus.ready;

  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid               = out_valid_r;
  assign out_bus.verdict             = out_verdict_r;
  assign out_bus.direction           = out_dir_r;
  assign out_bus.source_address      = out_saddr_r;
  assign out_bus.destination_address = out_daddr_r;

  // per-position field capture
  always_comb begin
    pos_n  = {1'b0, pos_r};
    n      = pos_n + NW'(1);
    t_old  = E_N + NW'({ihw_r, 2'b00});

    eth_ok_nxt = eth_ok_r;
    if (pos_n == E_N - NW'(1)) begin
      eth_ok_nxt = ({prev_r, s1_data_r} == ETHERTYPE_IPV4);
    end

    ihw_nxt = (pos_n == E_N) ? s1_data_r[3:0] : ihw_r;

    frag_nxt = frag_r
             | ((pos_n == E_N + NW'(6)) && ((s1_data_r & FRAG_HI_MASK) != 8'h00))
             | ((pos_n == E_N + NW'(7)) && (s1_data_r != 8'h00));

    proto_ok_nxt = (pos_n == E_N + NW'(9)) ? (s1_data_r == TCP_PROTOCOL_NUM) : proto_ok_r;

    saddr_nxt = saddr_r;
    if (pos_n >= E_N + NW'(12) && pos_n < E_N + NW'(16)) begin
      saddr_nxt = {saddr_r[23:0], s1_data_r};
    end
    daddr_nxt = daddr_r;
    if (pos_n >= E_N + NW'(16) && pos_n < E_N + NW'(20)) begin
      daddr_nxt = {daddr_r[23:0], s1_data_r};
    end

    // tcp fields only once a usable ip header length is known
    hdr_ok    = (ihw_r >= MIN_HDR_WORDS) && (pos_n > E_N);
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    thw_nxt   = thw_r;
    pay_ok_nxt = pay_ok_r;
    if (hdr_ok) begin
      if (pos_n == t_old || pos_n == t_old + NW'(1)) begin
        sport_nxt = {sport_r[7:0], s1_data_r};
      end
      if (pos_n == t_old + NW'(2) || pos_n == t_old + NW'(3)) begin
        dport_nxt = {dport_r[7:0], s1_data_r};
      end
      if (pos_n == t_old + NW'(12)) begin
        thw_nxt = s1_data_r[7:4];
      end
      if (thw_r >= MIN_HDR_WORDS && pos_n == t_old + NW'({thw_r, 2'b00})) begin
        pay_ok_nxt = (s1_data_r == start_byte_r);
      end
    end

    pos_nxt = (pos_r < POS_MAX) ? pos_r + PW'(1) : pos_r;
  end

  // verdict on the frame as it stands after this byte
  always_comb begin
    t_new = E_N + NW'({ihw_nxt, 2'b00});
    p_new = t_new + NW'({thw_nxt, 2'b00});
    dir_nxt = 1'b0;
    if (n < E_N) begin
      verdict_nxt = VD_TRUNCATED;
    end else if (!eth_ok_nxt) begin
      verdict_nxt = VD_NOT_IPV4;
    end else if (n < E_N + NW'(10)) begin
      verdict_nxt = VD_TRUNCATED;
    end else if (!proto_ok_nxt) begin
      verdict_nxt = VD_NOT_TCP;
    end else if (frag_nxt) begin
      verdict_nxt = VD_FRAGMENTED;
    end else if (ihw_nxt < MIN_HDR_WORDS) begin
      verdict_nxt = VD_MALFORMED;
    end else if (n < t_new + NW'(4)) begin
      verdict_nxt = VD_TRUNCATED;
    end else if (dport_nxt != service_port_r && sport_nxt != service_port_r) begin
      verdict_nxt = VD_NOT_PROTO;
    end else if (n < t_new + NW'(13)) begin
      verdict_nxt = VD_TRUNCATED;
    end else if (thw_nxt < MIN_HDR_WORDS) begin
      verdict_nxt = VD_MALFORMED;
    end else if (n < p_new + NW'(MIN_PAYLOAD) || !pay_ok_nxt) begin
      verdict_nxt = VD_NOT_PROTO;
    end else begin
      verdict_nxt = VD_OK;
      // destination match wins over source match
      dir_nxt = (dport_nxt != service_port_r);
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      service_port_r <= SERVICE_PORT_RESET;
      start_byte_r   <= START_BYTE_RESET;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_index_t'(cfg_bus.index))
        CFG_SERVICE_PORT: service_port_r <= cfg_bus.data[15:0];
        CFG_START_BYTE:   start_byte_r   <= cfg_bus.data[7:0];
        default:          ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_bus.data_byte;
      s1_last_r <= in_bus.last_byte;
    end
  end

  // frame state, cleared after each final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_fire && s1_last_r)) begin
      pos_r      <= '0;
      prev_r     <= '0;
      ihw_r      <= '0;
      thw_r      <= '0;
      sport_r    <= '0;
      dport_r    <= '0;
      saddr_r    <= '0;
      daddr_r    <= '0;
      pay_ok_r   <= 1'b0;
      eth_ok_r   <= 1'b0;
      proto_ok_r <= 1'b0;
      frag_r     <= 1'b0;
    end else if (s1_fire) begin
      pos_r      <= pos_nxt;
      prev_r     <= s1_data_r;
      ihw_r      <= ihw_nxt;
      thw_r      <= thw_nxt;
      sport_r    <= sport_nxt;
      dport_r    <= dport_nxt;
      saddr_r    <= saddr_nxt;
      daddr_r    <= daddr_nxt;
      pay_ok_r   <= pay_ok_nxt;
      eth_ok_r   <= eth_ok_nxt;
      proto_ok_r <= proto_ok_nxt;
      frag_r     <= frag_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_verdict_r <= verdict_nxt;
      if (verdict_nxt == VD_OK) begin
        out_dir_r   <= dir_nxt;
        out_saddr_r <= saddr_nxt;
        out_daddr_r <= daddr_nxt;
      end else begin
        out_dir_r   <= 1'b0;
        out_saddr_r <= '0;
        out_daddr_r <= '0;
      end
    end
  end

endmodule : iec104_frame_classifier

`default_nettype wire

// ===== src/iecfc_checker.sv =====
// port-level assertions for the iec104 frame classifier, bound to the top level
// depends on iecfc_pkg and iec104_frame_classifier

`default_nettype none

module iecfc_checker
  import iecfc_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        in_last,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  out_verdict,
  input wire        out_direction,
  input wire [31:0] out_saddr,
  input wire [31:0] out_daddr
);

  // a pending verdict is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_verdict) && $stable(out_saddr)
                                && $stable(out_daddr) && $stable(out_direction))
    else $error("out beat changed while stalled");

  // side fields are zero unless the frame is ok
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict != VD_OK |->
      !out_direction && out_saddr == 32'd0 && out_daddr == 32'd0)
    else $error("nonzero side fields on a rejected frame");

  // a final byte taken while the output is free is followed by a verdict
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last && !out_valid ##1 1'b1 |=> out_valid)
    else $error("verdict missing after final byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid right after reset");

endmodule : iecfc_checker

bind iec104_frame_classifier iecfc_checker u_iecfc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .in_last       (in_bus.last_byte),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_verdict   (out_bus.verdict),
  .out_direction (out_bus.direction),
  .out_saddr     (out_bus.source_address),
  .out_daddr     (out_bus.destination_address)
);

`default_nettype wire

// ===== dv/iec104_frame_classifier_tb.sv =====
// self-checking testbench for iec104_frame_classifier: frame bytes in, one verdict beat per frame
// uses iecfc_pkg and the channel interfaces from iecfc_ifs.sv
// directed frame table first, then random frames under several port/start byte settings

`timescale 1ns / 100ps

module iec104_frame_classifier_tb;
  import iecfc_pkg::*;

  localparam int MAX_FRAME   = 2048;
  localparam int ETH_HDR     = 14;
  localparam int CYCLE_LIMIT = 200_000;

  // how a directed row bends the well-formed base frame
  typedef enum logic [3:0] {
    TW_NONE, TW_CUT, TW_CUT_TCP, TW_ETHERTYPE, TW_PROTO, TW_FLAGS_HI, TW_FRAG_LO,
    TW_IHL, TW_DOFF, TW_PORTS, TW_PAY_LEN, TW_BAD_MARK, TW_ADDR_EXT, TW_LONG
  } tweak_t;

  // which tcp port carries the service port
  typedef enum logic [1:0] {PM_DST, PM_SRC, PM_BOTH, PM_NONE} port_mode_t;

  typedef struct packed {
    tweak_t     kind;
    logic [15:0] arg;
    logic       pinned;   // verdict typed in below instead of predicted
    verdict_t   verdict;
  } stim_row_t;

  typedef struct packed {
    logic [15:0] ethertype;
    logic [3:0]  ihl;
    logic [7:0]  flags_hi;
    logic [7:0]  frag_lo;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  doff;
    logic [15:0] pay_len;
    logic [7:0]  pay_first;
    logic [15:0] cut;     // frame length after truncation, zero keeps it whole
  } frame_spec_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        direction;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } verdict_beat_t;

  localparam int N_ROWS = 32;

  // directed frames, run at the reset configuration
  stim_row_t stim_table [N_ROWS] = '{
    '{TW_CUT,       16'd1,     1'b1, VD_TRUNCATED},   // single byte frame
    '{TW_CUT,       16'd13,    1'b1, VD_TRUNCATED},   // ends inside the ethertype
    '{TW_ETHERTYPE, 16'h86dd,  1'b1, VD_NOT_IPV4},
    '{TW_ETHERTYPE, 16'h0008,  1'b1, VD_NOT_IPV4},    // byte-swapped ipv4 type
    '{TW_CUT,       16'd14,    1'b1, VD_TRUNCATED},   // ethertype only
    '{TW_CUT,       16'd23,    1'b1, VD_TRUNCATED},   // one short of the protocol byte
    '{TW_CUT,       16'd24,    1'b1, VD_TRUNCATED},   // protocol seen, ports missing
    '{TW_PROTO,     16'd17,    1'b1, VD_NOT_TCP},
    '{TW_PROTO,     16'hff,    1'b1, VD_NOT_TCP},
    '{TW_FLAGS_HI,  16'h20,    1'b1, VD_FRAGMENTED},  // more-fragments flag
    '{TW_FLAGS_HI,  16'h01,    1'b1, VD_FRAGMENTED},  // offset high bits
    '{TW_FRAG_LO,   16'h80,    1'b1, VD_FRAGMENTED},
    '{TW_FLAGS_HI,  16'hc0,    1'b0, VD_OK},          // reserved and df bits are masked off
    '{TW_IHL,       16'd4,     1'b1, VD_MALFORMED},
    '{TW_IHL,       16'd0,     1'b1, VD_MALFORMED},
    '{TW_IHL,       16'd15,    1'b0, VD_OK},          // longest ip options
    '{TW_PORTS,     16'(PM_NONE), 1'b1, VD_NOT_PROTO},
    '{TW_PORTS,     16'(PM_SRC),  1'b0, VD_OK},       // backward
    '{TW_PORTS,     16'(PM_BOTH), 1'b0, VD_OK},       // destination wins
    '{TW_CUT_TCP,   16'd3,     1'b1, VD_TRUNCATED},   // inside the port fields
    '{TW_CUT_TCP,   16'd12,    1'b1, VD_TRUNCATED},   // just before the data offset
    '{TW_DOFF,      16'd4,     1'b1, VD_MALFORMED},
    '{TW_DOFF,      16'd0,     1'b1, VD_MALFORMED},
    '{TW_DOFF,      16'd15,    1'b0, VD_OK},          // longest tcp options
    '{TW_PAY_LEN,   16'd5,     1'b1, VD_NOT_PROTO},   // payload one short
    '{TW_PAY_LEN,   16'd0,     1'b1, VD_NOT_PROTO},
    '{TW_PAY_LEN,   16'd6,     1'b0, VD_OK},          // shortest good payload
    '{TW_BAD_MARK,  16'd0,     1'b1, VD_NOT_PROTO},
    '{TW_ADDR_EXT,  16'd0,     1'b0, VD_OK},
    '{TW_ADDR_EXT,  16'd1,     1'b0, VD_OK},
    '{TW_LONG,      16'd2100,  1'b0, VD_OK},          // past the position counter limit
    '{TW_NONE,      16'd0,     1'b0, VD_OK}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic rx_ready = 1'b0;

  always #5 clk = ~clk;

  iecfc_in_if  in_bus ();
  iecfc_out_if out_bus ();
  iecfc_cfg_if cfg_bus ();

  assign out_bus.ready = rx_ready;

  iec104_frame_classifier #(
    .MAX_FRAME_BYTES  (MAX_FRAME),
    .ETH_HEADER_BYTES (ETH_HDR)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // idle percentages for the sending and receiving sides
  int tx_idle_pct = 33;
  int rx_idle_pct = 50;

  // counters
  int mismatches   = 0;
  int frames_sent  = 0;
  int bytes_sent   = 0;
  int beats_seen   = 0;
  int cycle_count  = 0;
  int verdict_seen [7] = '{default: 0};

  // ------------------------------------------------------------------
  // classifier state as the predictor sees it
  // ------------------------------------------------------------------
  logic [15:0] svc_port;
  logic [7:0]  sof_byte;

  logic [10:0] fr_pos;
  logic [7:0]  fr_prev;
  logic [3:0]  fr_ihl;
  logic [3:0]  fr_thl;
  logic [15:0] fr_sport;
  logic [15:0] fr_dport;
  logic [31:0] fr_saddr;
  logic [31:0] fr_daddr;
  logic        fr_dir;
  logic        fr_pay_ok;
  logic        fr_eth_ok;
  logic        fr_proto_ok;
  logic        fr_frag;

  verdict_beat_t expected_verdicts [$];

  // typed-in verdict for the frame in flight, if its row has one
  logic     pin_valid = 1'b0;
  verdict_t pin_verdict = VD_OK;

  logic [7:0] frame_bytes [$];

  task automatic clear_frame_state();
    fr_pos      = '0;
    fr_prev     = '0;
    fr_ihl      = '0;
    fr_thl      = '0;
    fr_sport    = '0;
    fr_dport    = '0;
    fr_saddr    = '0;
    fr_daddr    = '0;
    fr_dir      = 1'b0;
    fr_pay_ok   = 1'b0;
    fr_eth_ok   = 1'b0;
    fr_proto_ok = 1'b0;
    fr_frag     = 1'b0;
  endtask

  // verdict for a frame of n bytes; checks in priority order
  function automatic verdict_t judge_frame(input int n);
    int t;
    int p;
    t = ETH_HDR + 4 * int'(fr_ihl);
    p = t + 4 * int'(fr_thl);
    if (n < ETH_HDR) return VD_TRUNCATED;
    if (!fr_eth_ok) return VD_NOT_IPV4;
    if (n < ETH_HDR + 10) return VD_TRUNCATED;
    if (!fr_proto_ok) return VD_NOT_TCP;
    if (fr_frag) return VD_FRAGMENTED;
    if (fr_ihl < MIN_HDR_WORDS) return VD_MALFORMED;
    if (n < t + 4) return VD_TRUNCATED;
    if (fr_dport == svc_port) fr_dir = 1'b0;
    else if (fr_sport == svc_port) fr_dir = 1'b1;
    else return VD_NOT_PROTO;
    if (n < t + 13) return VD_TRUNCATED;
    if (fr_thl < MIN_HDR_WORDS) return VD_MALFORMED;
    if (n < p + int'(MIN_PAYLOAD) || !fr_pay_ok) return VD_NOT_PROTO;
    return VD_OK;
  endfunction

  // fold one accepted byte into the frame state; on the last byte queue the verdict
  task automatic absorb_frame_byte(input logic [7:0] b, input logic last);
    int i;
    int t;
    verdict_t v;
    verdict_beat_t beat;
    i = int'(fr_pos);
    t = ETH_HDR + 4 * int'(fr_ihl);
    if (i == ETH_HDR - 1) fr_eth_ok = ({fr_prev, b} == ETHERTYPE_IPV4);
    if (i == ETH_HDR) fr_ihl = b[3:0];
    if (i == ETH_HDR + 6 && (b & FRAG_HI_MASK) != 8'h00) fr_frag = 1'b1;
    if (i == ETH_HDR + 7 && b != 8'h00) fr_frag = 1'b1;
    if (i == ETH_HDR + 9) fr_proto_ok = (b == TCP_PROTOCOL_NUM);
    if (i >= ETH_HDR + 12 && i < ETH_HDR + 16) fr_saddr = {fr_saddr[23:0], b};
    if (i >= ETH_HDR + 16 && i < ETH_HDR + 20) fr_daddr = {fr_daddr[23:0], b};
    if (fr_ihl >= MIN_HDR_WORDS && i > ETH_HDR) begin
      if (i == t || i == t + 1) fr_sport = {fr_sport[7:0], b};
      if (i == t + 2 || i == t + 3) fr_dport = {fr_dport[7:0], b};
      if (i == t + 12) fr_thl = b[7:4];
      if (fr_thl >= MIN_HDR_WORDS && i > t + 12 && i == t + 4 * int'(fr_thl))
        fr_pay_ok = (b == sof_byte);
    end
    fr_prev = b;
    if (int'(fr_pos) < MAX_FRAME - 1) fr_pos = fr_pos + 11'd1;
    if (last) begin
      v = judge_frame(i + 1);
      beat = '{verdict: v, direction: 1'b0, src_addr: '0, dst_addr: '0};
      if (v == VD_OK) begin
        beat.direction = fr_dir;
        beat.src_addr  = fr_saddr;
        beat.dst_addr  = fr_daddr;
      end
      if (pin_valid) begin
        beat = '{verdict: pin_verdict, direction: 1'b0, src_addr: '0, dst_addr: '0};
        pin_valid = 1'b0;
      end
      expected_verdicts.push_back(beat);
      clear_frame_state();
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s, verdict beat %0d: got 0x%0h, want 0x%0h",
             $time, field, beats_seen, got, want);
  endtask

  // ------------------------------------------------------------------
  // scoreboard: everything sampled at the rising edge, output side first
  // ------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    verdict_beat_t want;
    if (!rst_n) begin
      svc_port = SERVICE_PORT_RESET;
      sof_byte = START_BYTE_RESET;
      clear_frame_state();
    end else begin
      // verdict beat leaving the block
      if (out_bus.valid && out_bus.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected verdict beat", 32'(out_bus.verdict), 32'd0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_bus.verdict !== want.verdict)
            report_mismatch("verdict", 32'(out_bus.verdict), 32'(want.verdict));
          if (out_bus.direction !== want.direction)
            report_mismatch("direction", 32'(out_bus.direction), 32'(want.direction));
          if (out_bus.source_address !== want.src_addr)
            report_mismatch("source_address", out_bus.source_address, want.src_addr);
          if (out_bus.destination_address !== want.dst_addr)
            report_mismatch("destination_address", out_bus.destination_address,
                            want.dst_addr);
        end
        if (out_bus.verdict < 3'd7) verdict_seen[out_bus.verdict]++;
        beats_seen++;
      end
      // register write, only ever between frames
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_index_t'(cfg_bus.index))
          CFG_SERVICE_PORT: svc_port = cfg_bus.data[15:0];
          CFG_START_BYTE:   sof_byte = cfg_bus.data[7:0];
          default: ;
        endcase
      end
      // frame byte entering the block
      if (in_bus.valid && in_bus.ready)
        absorb_frame_byte(in_bus.data_byte, in_bus.last_byte);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cycle limit reached, %0d verdict beats still outstanding",
               expected_verdicts.size());
      $display("FAILURE");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) rx_ready <= ($urandom_range(99) >= rx_idle_pct);

  // ------------------------------------------------------------------
  // frame construction
  // ------------------------------------------------------------------

  // random port that does not collide with the service port
  function automatic logic [15:0] other_port();
    logic [15:0] p;
    p = 16'($urandom);
    if (p == svc_port) p = p + 16'd1;
    return p;
  endfunction

  function automatic frame_spec_t with_ports(input frame_spec_t s, input port_mode_t m);
    s.sport = (m == PM_SRC || m == PM_BOTH) ? svc_port : other_port();
    s.dport = (m == PM_DST || m == PM_BOTH) ? svc_port : other_port();
    return s;
  endfunction

  // well-formed forward frame with random addresses and content
  function automatic frame_spec_t base_frame();
    frame_spec_t s;
    s.ethertype = ETHERTYPE_IPV4;
    s.ihl       = MIN_HDR_WORDS;
    s.flags_hi  = {2'($urandom), 6'b0};
    s.frag_lo   = 8'h00;
    s.proto     = TCP_PROTOCOL_NUM;
    s.src_ip    = $urandom;
    s.dst_ip    = $urandom;
    s.doff      = MIN_HDR_WORDS;
    s.pay_len   = 16'($urandom_range(6, 24));
    s.pay_first = sof_byte;
    s.cut       = '0;
    return with_ports(s, PM_DST);
  endfunction

  function automatic frame_spec_t directed_frame(input stim_row_t r);
    frame_spec_t s;
    s = base_frame();
    case (r.kind)
      TW_CUT:       s.cut = r.arg;
      TW_CUT_TCP:   s.cut = 16'(ETH_HDR + 4 * int'(s.ihl) + int'(r.arg));
      TW_ETHERTYPE: s.ethertype = r.arg;
      TW_PROTO:     s.proto = r.arg[7:0];
      TW_FLAGS_HI:  s.flags_hi = r.arg[7:0];
      TW_FRAG_LO:   s.frag_lo = r.arg[7:0];
      TW_IHL:       s.ihl = r.arg[3:0];
      TW_DOFF:      s.doff = r.arg[3:0];
      TW_PORTS:     s = with_ports(s, port_mode_t'(r.arg[1:0]));
      TW_PAY_LEN:   s.pay_len = r.arg;
      TW_BAD_MARK:  s.pay_first = ~sof_byte;
      TW_ADDR_EXT: begin
        s.src_ip = r.arg[0] ? 32'hffff_ffff : 32'h0000_0000;
        s.dst_ip = ~s.src_ip;
      end
      TW_LONG:      s.pay_len = r.arg;
      default: ;
    endcase
    return s;
  endfunction

  // lay the frame out byte by byte into frame_bytes
  task automatic build_frame(input frame_spec_t s);
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));     // mac addresses
    frame_bytes.push_back(s.ethertype[15:8]);
    frame_bytes.push_back(s.ethertype[7:0]);
    frame_bytes.push_back({4'h4, s.ihl});
    repeat (5) frame_bytes.push_back(8'($urandom));      // tos, length, id
    frame_bytes.push_back(s.flags_hi);
    frame_bytes.push_back(s.frag_lo);
    frame_bytes.push_back(8'($urandom));                 // ttl
    frame_bytes.push_back(s.proto);
    repeat (2) frame_bytes.push_back(8'($urandom));      // checksum
    for (int k = 3; k >= 0; k--) frame_bytes.push_back(s.src_ip[8*k +: 8]);
    for (int k = 3; k >= 0; k--) frame_bytes.push_back(s.dst_ip[8*k +: 8]);
    if (s.ihl > MIN_HDR_WORDS)
      repeat (4 * (int'(s.ihl) - 5)) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(s.sport[15:8]);
    frame_bytes.push_back(s.sport[7:0]);
    frame_bytes.push_back(s.dport[15:8]);
    frame_bytes.push_back(s.dport[7:0]);
    repeat (8) frame_bytes.push_back(8'($urandom));      // seq and ack
    frame_bytes.push_back({s.doff, 4'($urandom)});
    repeat (7) frame_bytes.push_back(8'($urandom));      // flags, window, csum, urgent
    if (s.doff > MIN_HDR_WORDS)
      repeat (4 * (int'(s.doff) - 5)) frame_bytes.push_back(8'($urandom));
    if (s.pay_len != 0) begin
      frame_bytes.push_back(s.pay_first);
      repeat (int'(s.pay_len) - 1) frame_bytes.push_back(8'($urandom));
    end
    if (s.cut != 0)
      while (frame_bytes.size() > int'(s.cut)) void'(frame_bytes.pop_back());
  endtask

  // mostly well-formed frames with random content, some broken, a few pure noise
  task automatic make_random_frame();
    frame_spec_t s;
    int pick;
    int len;
    logic trim;
    pick = $urandom_range(99);
    trim = 1'b0;
    if (pick < 10) begin
      frame_bytes.delete();
      len = $urandom_range(1, 80);
      repeat (len) frame_bytes.push_back(8'($urandom));
    end else begin
      s = with_ports(base_frame(), port_mode_t'($urandom_range(3)));
      if ($urandom_range(2) == 0) s.ihl = 4'($urandom_range(6, 15));
      if ($urandom_range(2) == 0) s.doff = 4'($urandom_range(6, 15));
      if ($urandom_range(3) == 0) s.pay_len = 16'($urandom_range(0, 8));
      if ($urandom_range(7) == 0) s.pay_first = 8'($urandom);
      if ($urandom_range(7) == 0) s.flags_hi = 8'($urandom);
      // one broken field or a cut in about a quarter of the frames
      if (pick >= 75) begin
        case ($urandom_range(6))
          0: s.ethertype = 16'($urandom);
          1: s.proto = 8'($urandom);
          2: s.flags_hi = 8'($urandom);
          3: s.frag_lo = 8'($urandom);
          4: s.ihl = 4'($urandom_range(0, 4));
          5: s.doff = 4'($urandom_range(0, 4));
          default: trim = 1'b1;
        endcase
      end
      build_frame(s);
      if (trim) begin
        s.cut = 16'($urandom_range(1, frame_bytes.size()));
        build_frame(s);
      end
    end
  endtask

  // ------------------------------------------------------------------
  // drivers, all changes at the falling edge
  // ------------------------------------------------------------------

  // one byte beat; called and returns just after a falling edge
  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid     <= 1'b0;
      in_bus.data_byte <= 8'($urandom);
      in_bus.last_byte <= 1'($urandom);
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic pinned, input verdict_t verdict);
    int last_idx;
    last_idx = frame_bytes.size() - 1;
    pin_valid   = pinned;
    pin_verdict = verdict;
    for (int k = 0; k <= last_idx; k++) send_beat(frame_bytes[k], k == last_idx);
    frames_sent++;
  endtask

  // drop valid and let every verdict drain before going on
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  // random frames until enough verdicts have been produced in this setting
  task automatic run_random_phase();
    int f0;
    int b0;
    f0 = frames_sent;
    b0 = bytes_sent;
    while (frames_sent - f0 < 16 || bytes_sent - b0 < 220) begin
      make_random_frame();
      send_frame(1'b0, VD_OK);
    end
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last_byte = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = CFG_SERVICE_PORT;
    cfg_bus.data     = '0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames at the reset configuration, sender idles 33 / receiver 50
    for (int r = 0; r < N_ROWS; r++) begin
      build_frame(directed_frame(stim_table[r]));
      send_frame(stim_table[r].pinned, stim_table[r].verdict);
    end

    // low extremes: port 0, start byte 0x00 (upper data bits are don't care)
    wait_idle();
    write_reg(CFG_SERVICE_PORT, 16'h0000);
    write_reg(CFG_START_BYTE, {8'($urandom), 8'h00});
    run_random_phase();

    // high extremes, idling swapped between the two sides
    wait_idle();
    tx_idle_pct = 50;
    rx_idle_pct = 33;
    write_reg(CFG_SERVICE_PORT, 16'hffff);
    write_reg(CFG_START_BYTE, {8'($urandom), 8'hff});
    run_random_phase();

    // random setting at full rate on both sides
    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_SERVICE_PORT, 16'($urandom));
    write_reg(CFG_START_BYTE, 16'($urandom));
    run_random_phase();

    wait_idle();
    $display("covered %0d frames (%0d byte beats) over four port/start byte settings,",
             frames_sent, bytes_sent);
    $display("%0d verdicts checked, mix ok/ipv4/tcp/frag/proto/malformed/trunc: %0d %0d %0d %0d %0d %0d %0d",
             beats_seen, verdict_seen[0], verdict_seen[1], verdict_seen[2],
             verdict_seen[3], verdict_seen[4], verdict_seen[5], verdict_seen[6]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule : iec104_frame_classifier_tb
